// File: hw/rtl/are_pkg.sv
// ----------------------------------------------------------------------------
// are_pkg
// Shared types and constants of the audio ramp envelope.
// ----------------------------------------------------------------------------
package are_pkg;

    localparam int LEN_W      = 20;
    localparam int GAIN_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = LEN_W + FRAC_W;
    localparam int CFG_IDX_W  = 8;
    localparam int DIV_STEPS  = GAIN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [GAIN_W-1:0]    UNITY       = GAIN_W'(1) << FRAC_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_FADE    = 2'd1,
        PH_ATTACK  = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        G_ZERO = 2'd0,
        G_QUO  = 2'd1,
        G_INV  = 2'd2
    } t_gsel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_DIV,
        S_GAIN,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic take_in;
        logic plan;
        logic div_step;
        logic gain;
        logic mul;
        logic load_out;
    } t_ctrl_cmd;

endpackage

// File: hw/rtl/are_if.sv
// ----------------------------------------------------------------------------
// are_if
// Request channels of the audio ramp envelope: samples, results, config.
// ----------------------------------------------------------------------------
interface are_smp_if #(parameter int SAMPLE_WIDTH = 24);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           trigger;

    modport source(output valid, sample_in, trigger, input ready);
    modport sink(input valid, sample_in, trigger, output ready);
endinterface

interface are_res_if #(parameter int SAMPLE_WIDTH = 24);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic [1:0]                     phase;

    modport source(output valid, sample_out, phase, input ready);
    modport sink(input valid, sample_out, phase, output ready);
endinterface

interface are_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [19:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/audio_ramp_envelope.sv
// ----------------------------------------------------------------------------
// audio_ramp_envelope
// Attack-then-release gain envelope with block-aligned fade on retrigger.
//
//   channel   dir  payload                       handshake
//   i_smp     in   sample_in, trigger            valid / ready
//   o_res     out  sample_out, phase             valid / ready
//   i_cfg     in   index (0 attack, 1 release),  valid / ready (ready out of reset)
//                  data
//
// Each sample is accepted, planned, then run through the shared restoring
// divider (one quotient bit per cycle), then gain, multiply and hand-off.
// The divider sets the rate.
// Reset is synchronous and clears phase, counters, held gain and lengths.
// A stalled result waits in the output register; the next sample is taken
// meanwhile and its result is held until the register frees up.
// ----------------------------------------------------------------------------
module audio_ramp_envelope
    import are_pkg::*;
#(
    parameter int BLOCK_SIZE   = 128,
    parameter int SAMPLE_WIDTH = 24
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    are_smp_if.sink   i_smp,
    are_res_if.source o_res,
    are_cfg_if.sink   i_cfg
);

    t_ctrl_cmd w_cmd;
    logic      w_in_ready;
    logic      w_out_free;

    assign i_smp.ready = w_in_ready;
    assign i_cfg.ready = i_rst_n;

    are_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (w_in_ready),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd)
    );

    are_dp #(
        .BLOCK_SIZE   (BLOCK_SIZE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_sample_in  (i_smp.sample_in),
        .i_trigger    (i_smp.trigger),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_out_valid  (o_res.valid),
        .i_out_ready  (o_res.ready),
        .o_sample_out (o_res.sample_out),
        .o_phase      (o_res.phase),
        .o_out_free   (w_out_free)
    );

endmodule

// File: hw/rtl/are_ctrl.sv
// ----------------------------------------------------------------------------
// are_ctrl
// Sequencer: accept, plan, divide, scale, multiply, hand off.
// ----------------------------------------------------------------------------
module are_ctrl
    import are_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_out_free,
    output t_ctrl_cmd o_cmd
);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/are_dp.sv
// ----------------------------------------------------------------------------
// are_dp
// Envelope state, gain divider, sample scaling and result register.
// ----------------------------------------------------------------------------
module are_dp
    import are_pkg::*;
#(
    parameter int BLOCK_SIZE   = 128,
    parameter int SAMPLE_WIDTH = 24
)(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ctrl_cmd                      i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_trigger,
    input  logic                           i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [LEN_W-1:0]               i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic [1:0]                     o_phase,
    output logic                           o_out_free
);

    localparam int PW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int SW = SAMPLE_WIDTH;
    localparam logic [PW:0]      BLK      = (PW + 1)'(BLOCK_SIZE);
    localparam logic [PW-1:0]    POS_LAST = PW'(BLOCK_SIZE - 1);
    localparam logic [LEN_W-1:0] BLK_DEN  = LEN_W'(BLOCK_SIZE);

    logic [LEN_W-1:0]    r_att, r_rel;
    t_phase              r_phase, n_phase;
    logic [LEN_W-1:0]    r_ramp, n_ramp;
    logic [PW-1:0]       r_pos, n_pos;
    logic [GAIN_W-1:0]   r_held;

    logic signed [SW-1:0] r_smp;
    logic                 r_trig;

    t_gsel               r_gsel, n_gsel;
    logic                r_upd, n_upd;
    logic [NUM_W-1:0]    n_num;
    logic [LEN_W-1:0]    r_den, n_den;
    logic [LEN_W-1:0]    r_rem;
    logic [GAIN_W-1:0]   r_numlo;
    logic [GAIN_W-1:0]   r_quo;
    logic [LEN_W:0]      w_trial;
    logic                w_fit;

    logic [GAIN_W-1:0]   r_gain, n_gain;
    logic [SW-1:0]       r_mag;
    logic                r_neg;
    logic [SW+GAIN_W-1:0] r_prod;
    logic [SW-1:0]       w_scaled;

    logic                r_out_valid;
    logic signed [SW-1:0] r_out_smp;
    t_phase              r_out_phase;

    logic [PW:0]               w_rest;
    logic [GAIN_W+PW:0]        w_fade_num;
    logic                      w_to_rel;

    assign w_rest     = BLK - {1'b0, r_pos};
    assign w_fade_num = r_held * w_rest;

    // envelope step
    always_comb begin
        n_phase  = r_phase;
        n_ramp   = r_ramp;
        n_gsel   = G_ZERO;
        n_upd    = 1'b0;
        n_num    = '0;
        n_den    = BLK_DEN;
        w_to_rel = 1'b0;
        n_pos    = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
        if (r_trig) begin
            n_ramp  = '0;
            n_phase = PH_FADE;
        end
        unique case (n_phase)
            PH_FADE: begin
                n_num  = NUM_W'(w_fade_num);
                n_gsel = G_QUO;
                if (r_pos == POS_LAST) begin
                    n_phase = PH_ATTACK;
                end
            end
            PH_ATTACK, PH_RELEASE: begin
                n_upd    = 1'b1;
                w_to_rel = (n_phase == PH_RELEASE);
                if (n_phase == PH_ATTACK) begin
                    if (n_ramp < r_att) begin
                        n_num  = {n_ramp, FRAC_W'(0)};
                        n_den  = r_att;
                        n_gsel = G_QUO;
                        n_ramp = n_ramp + 1'b1;
                    end else begin
                        n_ramp   = '0;
                        n_phase  = PH_RELEASE;
                        w_to_rel = 1'b1;
                    end
                end
                if (w_to_rel) begin
                    if (n_ramp < r_rel) begin
                        n_num  = {n_ramp, FRAC_W'(0)};
                        n_den  = r_rel;
                        n_gsel = G_INV;
                        n_ramp = n_ramp + 1'b1;
                    end else begin
                        n_gsel  = G_ZERO;
                        n_ramp  = '0;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_gsel = G_ZERO;
            end
        endcase
    end

    assign w_trial = {r_rem, r_numlo[GAIN_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_comb begin
        case (r_gsel)
            G_QUO:   n_gain = r_quo;
            G_INV:   n_gain = UNITY - r_quo;
            default: n_gain = '0;
        endcase
    end

    assign w_scaled = r_prod[SW+FRAC_W-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att       <= '0;
            r_rel       <= '0;
            r_phase     <= PH_IDLE;
            r_ramp      <= '0;
            r_pos       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ATTACK:  r_att <= i_cfg_data;
                    CFG_RELEASE: r_rel <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.plan) begin
                r_phase <= n_phase;
                r_ramp  <= n_ramp;
                r_pos   <= n_pos;
            end
            if (i_cmd.gain && r_upd) begin
                r_held <= n_gain;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_smp  <= i_sample_in;
            r_trig <= i_trigger;
        end
        if (i_cmd.plan) begin
            r_gsel  <= n_gsel;
            r_upd   <= n_upd;
            r_den   <= n_den;
            r_rem   <= {1'b0, n_num[NUM_W-1:GAIN_W]};
            r_numlo <= n_num[GAIN_W-1:0];
            r_quo   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem   <= w_fit ? LEN_W'(w_trial - {1'b0, r_den}) : w_trial[LEN_W-1:0];
            r_numlo <= {r_numlo[GAIN_W-2:0], 1'b0};
            r_quo   <= {r_quo[GAIN_W-2:0], w_fit};
        end
        if (i_cmd.gain) begin
            r_gain <= n_gain;
            r_neg  <= r_smp[SW-1];
            r_mag  <= r_smp[SW-1] ? SW'(-r_smp) : SW'(r_smp);
        end
        if (i_cmd.mul) begin
            r_prod <= r_mag * r_gain;
        end
        if (i_cmd.load_out) begin
            r_out_smp   <= r_neg ? $signed(-w_scaled) : $signed(w_scaled);
            r_out_phase <= r_phase;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_smp;
    assign o_phase      = r_out_phase;
    assign o_out_free   = !r_out_valid || i_out_ready;

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= UNITY)
        else $error("held gain above unity");

    a_ramp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_FADE) |-> (r_ramp == '0))
        else $error("ramp count not clear outside a ramp");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < BLK)
        else $error("block position out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

endmodule

// File: tb/tb_audio_ramp_envelope.sv
// ----------------------------------------------------------------------------
// tb_audio_ramp_envelope
// Self-checking bench for the attack/release envelope with block-aligned fade.
//
// Samples are queued by phase, each phase under its own pair of ramp lengths.
// The sample driver and the result monitor run as clocked processes with
// random idle bursts on both sides. The monitor compares every result against
// the oldest prediction. Predictions come from a local envelope model that is
// advanced on every accepted sample. One long receiver hold-off backs the
// block up until it stops taking samples.
// ----------------------------------------------------------------------------
module tb_audio_ramp_envelope
    import are_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK        = 128;
    localparam int SW           = 24;
    localparam int POS_W        = $clog2(BLOCK);
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 trigger;
    } t_smp_req;

    typedef struct packed {
        logic signed [SW-1:0] sample_out;
        t_phase               phase;
    } t_env_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    are_smp_if #(.SAMPLE_WIDTH(SW)) smp_if ();
    are_res_if #(.SAMPLE_WIDTH(SW)) res_if ();
    are_cfg_if                      cfg_if ();

    audio_ramp_envelope #(
        .BLOCK_SIZE  (BLOCK),
        .SAMPLE_WIDTH(SW)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    always #10 i_clk = ~i_clk;

    // envelope model state
    t_phase             env_phase = PH_IDLE;
    logic [LEN_W-1:0]   env_count = '0;
    logic [POS_W-1:0]   env_pos   = '0;
    logic [GAIN_W-1:0]  env_held  = '0;
    logic [LEN_W-1:0]   len_attack;
    logic [LEN_W-1:0]   len_release;

    t_smp_req pending_samples[$];
    t_env_res expected_out[$];

    int  n_queued;
    int  n_accepted;
    int  n_checked;
    int  n_settings;
    int  mismatches;
    int  cycles;
    bit  calm;
    bit  hold_rx;
    int  send_gap;
    int  recv_stall;

    t_smp_req next_req;
    t_env_res got_res;
    t_env_res want_res;

    function automatic logic signed [SW-1:0] scale_sample(logic signed [SW-1:0] s,
                                                          logic [GAIN_W-1:0] g);
        longint mag;
        bit     neg;
        neg = s[SW-1];
        mag = longint'(s);
        if (neg) mag = -mag;
        mag = (mag * longint'(g)) >>> FRAC_W;
        if (neg) mag = -mag;
        return SW'(mag);
    endfunction

    function automatic t_env_res step_envelope(t_smp_req req);
        logic [GAIN_W-1:0] gain;
        t_env_res          r;
        gain = '0;
        if (req.trigger) begin
            env_count = '0;
            env_phase = PH_FADE;
        end
        if (env_phase == PH_FADE) begin
            gain = GAIN_W'((longint'(env_held) * longint'(BLOCK - int'(env_pos))) / BLOCK);
            if (int'(env_pos) == BLOCK - 1) env_phase = PH_ATTACK;
        end else if (env_phase == PH_ATTACK || env_phase == PH_RELEASE) begin
            if (env_phase == PH_ATTACK) begin
                if (env_count < len_attack) begin
                    gain = GAIN_W'((longint'(env_count) <<< FRAC_W) / longint'(len_attack));
                    env_count = env_count + 1'b1;
                end else begin
                    env_count = '0;
                    env_phase = PH_RELEASE;
                end
            end
            if (env_phase == PH_RELEASE) begin
                if (env_count < len_release) begin
                    gain = UNITY - GAIN_W'((longint'(env_count) <<< FRAC_W)
                                           / longint'(len_release));
                    env_count = env_count + 1'b1;
                end else begin
                    gain = '0;
                    env_count = '0;
                    env_phase = PH_IDLE;
                end
            end
            env_held = gain;
        end
        env_pos = (int'(env_pos) == BLOCK - 1) ? '0 : env_pos + 1'b1;
        r.sample_out = scale_sample(req.sample, gain);
        r.phase      = env_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid     <= 1'b0;
            smp_if.sample_in <= '0;
            smp_if.trigger   <= 1'b0;
            send_gap = 0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                expected_out.push_back(step_envelope(next_req));
                n_accepted++;
            end
            if (!(smp_if.valid && !smp_if.ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    smp_if.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 16) - 1;
                    smp_if.valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    next_req = pending_samples.pop_front();
                    smp_if.valid     <= 1'b1;
                    smp_if.sample_in <= next_req.sample;
                    smp_if.trigger   <= next_req.trigger;
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got_res.sample_out = res_if.sample_out;
                got_res.phase      = t_phase'(res_if.phase);
                if (expected_out.size() == 0) begin
                    report_mismatch("result with no sample outstanding");
                end else begin
                    want_res = expected_out.pop_front();
                    n_checked++;
                    if (got_res.sample_out !== want_res.sample_out)
                        report_mismatch($sformatf("sample_out %0d, expected %0d",
                                                  got_res.sample_out, want_res.sample_out));
                    if (got_res.phase !== want_res.phase)
                        report_mismatch($sformatf("phase %0d, expected %0d",
                                                  got_res.phase, want_res.phase));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                recv_stall = $urandom_range(1, 16);
            end
            res_if.ready <= !hold_rx && recv_stall == 0;
        end
    end

    // long receiver hold-off while samples keep coming
    initial begin
        hold_rx = 1'b0;
        do @(posedge i_clk); while (!(n_accepted >= 300 && pending_samples.size() > 20));
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout: %0d samples accepted, %0d results outstanding",
                     n_accepted, expected_out.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            2:       return SW'($signed($urandom_range(0, 2)) - 1);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic signed [SW-1:0] s, input logic trig);
        t_smp_req r;
        r.sample  = s;
        r.trigger = trig;
        pending_samples.push_back(r);
        n_queued++;
    endtask

    task automatic queue_run(input int n, input bit lead, input bit retrig);
        for (int i = 0; i < n; i++)
            push_sample(pick_sample(), (i == 0 && lead) || (retrig && $urandom_range(0, 39) == 0));
    endtask

    task automatic write_length(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] len);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= len;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_ATTACK) len_attack = len;
        else len_release = len;
    endtask

    task automatic set_lengths(input logic [LEN_W-1:0] att, input logic [LEN_W-1:0] rel);
        write_length(CFG_ATTACK, att);
        write_length(CFG_RELEASE, rel);
        n_settings++;
    endtask

    task automatic settle();
        do @(posedge i_clk); while (n_accepted != n_queued || expected_out.size() != 0);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        return ($urandom_range(0, 2) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 40));
    endfunction

    initial begin
        i_rst_n          = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        calm             = 1'b0;
        len_attack       = '0;
        len_release      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle extremes, trigger, retrigger inside the fade
        set_lengths('0, LEN_W'(3));
        push_sample({1'b0, {(SW-1){1'b1}}}, 1'b0);
        push_sample({1'b1, {(SW-1){1'b0}}}, 1'b0);
        push_sample('0, 1'b0);
        push_sample('1, 1'b0);
        push_sample(SW'(1), 1'b0);
        push_sample({1'b0, {(SW-1){1'b1}}}, 1'b1);
        push_sample({1'b1, {(SW-1){1'b0}}}, 1'b1);
        push_sample('1, 1'b0);
        push_sample(SW'(1), 1'b1);
        for (int i = 0; i < 15; i++)
            push_sample(pick_sample(), 1'b0);
        settle();

        // zero lengths, unit lengths, short ramps
        set_lengths('0, '0);
        queue_run(100, 1'b1, 1'b1);
        settle();
        set_lengths('0, LEN_W'(5));
        queue_run(100, 1'b1, 1'b1);
        settle();
        set_lengths(LEN_W'(9), '0);
        queue_run(100, 1'b1, 1'b1);
        settle();
        set_lengths(LEN_W'(1), LEN_W'(1));
        queue_run(100, 1'b1, 1'b1);
        settle();

        // longest ramps, then shorten attack and release mid-ramp
        set_lengths(LEN_MAX, LEN_MAX);
        queue_run(160, 1'b1, 1'b0);
        settle();
        set_lengths(LEN_W'(3), LEN_MAX);
        queue_run(40, 1'b0, 1'b0);
        settle();
        set_lengths(LEN_W'(3), LEN_W'(2));
        queue_run(40, 1'b0, 1'b0);
        settle();

        for (int p = 0; p < 5; p++) begin
            set_lengths(pick_length(), pick_length());
            queue_run(100, 1'b1, 1'b1);
            settle();
        end

        // no idling on either side
        calm = 1'b1;
        set_lengths(LEN_W'($urandom_range(0, 20)), LEN_W'($urandom_range(0, 20)));
        queue_run(130, 1'b1, 1'b1);
        settle();

        repeat (40) @(posedge i_clk);
        if (expected_out.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_out.size()));

        $display("run covered %0d samples under %0d length settings, %0d results compared",
                 n_accepted, n_settings, n_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/are_pkg.sv
hw/rtl/are_if.sv
hw/rtl/are_ctrl.sv
hw/rtl/are_dp.sv
hw/rtl/audio_ramp_envelope.sv
tb/tb_audio_ramp_envelope.sv
